// ===== sv/spi_9bit_panel_master_assert.svh =====
// Assertion macros shared by the serial panel master RTL.
`ifndef SPI_9BIT_PANEL_MASTER_ASSERT_SVH
`define SPI_9BIT_PANEL_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPM_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("spm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPM_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("spm: next-cycle check failed");

`endif

// ===== sv/spm_pkg.sv =====
// Types, codes and reset state of the serial panel master.
package spm_pkg;

  localparam int MAX_READ_BYTES = 4;
  localparam int BYTES_W        = $clog2(MAX_READ_BYTES + 1);

  // Start codes carried by the op field
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CMD   = 2'd1,
    OP_PARAM = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Running job, same coding as the start codes
  typedef enum logic [1:0] {
    JOB_IDLE  = 2'd0,
    JOB_CMD   = 2'd1,
    JOB_PARAM = 2'd2,
    JOB_READ  = 2'd3
  } job_t;

  // Pin phases of the serial sequencer
  typedef enum logic [13:0] {
    PH_PRE_CS     = 14'h0001,
    PH_PRE_CLK    = 14'h0002,
    PH_SEL        = 14'h0004,
    PH_DC_LOW     = 14'h0008,
    PH_DC_DATA    = 14'h0010,
    PH_DC_HIGH    = 14'h0020,
    PH_BIT_LOW    = 14'h0040,
    PH_BIT_DATA   = 14'h0080,
    PH_BIT_HIGH   = 14'h0100,
    PH_DUMMY_LOW  = 14'h0200,
    PH_DUMMY_HIGH = 14'h0400,
    PH_RD_LOW     = 14'h0800,
    PH_RD_HIGH    = 14'h1000,
    PH_DESEL      = 14'h2000
  } phase_t;

  typedef struct packed {
    logic cs;
    logic clk;
    logic sdo;
    logic drv;
  } pins_t;

  typedef struct packed {
    job_t                 job;
    phase_t               phase;
    logic [2:0]           bit_idx;
    logic [BYTES_W-1:0]   bytes_left;
    logic [7:0]           shift;
    logic [7:0]           ticks;
    pins_t                pins;
  } state_t;

  typedef struct packed {
    logic       cs_level;
    logic       sclk_level;
    logic       sdo_level;
    logic       sdo_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
  } result_t;

  localparam state_t ST_RESET = '{
    job:        JOB_IDLE,
    phase:      PH_PRE_CS,
    bit_idx:    3'd7,
    bytes_left: '0,
    shift:      8'd0,
    ticks:      8'd0,
    pins:       '{cs: 1'b1, clk: 1'b1, sdo: 1'b0, drv: 1'b1}
  };

endpackage

// ===== sv/spm_in_if.sv =====
// Input channel: one tick beat with an optional job start.
interface spm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_value;
  logic [2:0] read_count;
  logic       sdi_in;

  modport source (output valid, op, byte_value, read_count, sdi_in, input ready);
  modport sink   (input valid, op, byte_value, read_count, sdi_in, output ready);
endinterface

// ===== sv/spm_out_if.sv =====
// Output channel: pin levels and received data for one tick.
interface spm_out_if;
  logic       valid;
  logic       ready;
  logic       cs_level;
  logic       sclk_level;
  logic       sdo_level;
  logic       sdo_drive;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_last;
  logic       busy_res;

  modport source (output valid, cs_level, sclk_level, sdo_level, sdo_drive, read_byte,
                  read_valid, read_last, busy_res, input ready);
  modport sink   (input valid, cs_level, sclk_level, sdo_level, sdo_drive, read_byte,
                  read_valid, read_last, busy_res, output ready);
endinterface

// ===== sv/spm_step.sv =====
// One tick of the pin sequencer: next state and pin result.
module spm_step (
  input  spm_pkg::state_t  st,
  input  logic [1:0]       op,
  input  logic [7:0]       byte_value,
  input  logic [2:0]       read_count,
  input  logic             sdi_in,
  input  logic [7:0]       phase_ticks,
  output spm_pkg::state_t  st_next,
  output spm_pkg::result_t res
);
  import spm_pkg::*;

  typedef struct packed {
    state_t st;
    logic   got_valid;
    logic   got_last;
  } step_t;

  // Back to idle; a read gives the data line back to the master
  function automatic step_t go_idle(step_t s);
    step_t r;
    r = s;
    if (s.st.job == JOB_READ) begin
      r.st.pins.drv = 1'b1;
      r.st.pins.sdo = 1'b0;
    end
    r.st.job     = JOB_IDLE;
    r.st.phase   = PH_PRE_CS;
    r.st.ticks   = 8'd0;
    r.st.bit_idx = 3'd7;
    return r;
  endfunction

  // Apply the pin action of a phase on entry
  function automatic step_t enter_ph(step_t s, phase_t ph, logic sdi);
    step_t r;
    r = s;
    r.st.phase = ph;
    r.st.ticks = 8'd0;
    unique case (ph)
      PH_PRE_CS, PH_DESEL: r.st.pins.cs = 1'b1;
      PH_SEL:              r.st.pins.cs = 1'b0;
      PH_PRE_CLK, PH_DC_HIGH, PH_BIT_HIGH, PH_DUMMY_HIGH: r.st.pins.clk = 1'b1;
      PH_DC_LOW, PH_BIT_LOW: r.st.pins.clk = 1'b0;
      PH_DC_DATA:  r.st.pins.sdo = (s.st.job == JOB_PARAM);
      PH_BIT_DATA: r.st.pins.sdo = s.st.shift[s.st.bit_idx];
      PH_DUMMY_LOW, PH_RD_LOW: begin
        r.st.pins.clk = 1'b0;
        r.st.pins.drv = 1'b0;
        r.st.pins.sdo = 1'b0;
      end
      PH_RD_HIGH: begin
        // sample the line seen at the end of the low phase
        r.st.shift = {s.st.shift[6:0], sdi};
        if (s.st.bit_idx == 3'd0) begin
          if (s.st.bytes_left != '0) r.st.bytes_left = s.st.bytes_left - BYTES_W'(1);
          r.got_valid = 1'b1;
          r.got_last  = (r.st.bytes_left == '0);
        end
        r.st.pins.clk = 1'b1;
      end
      default: r = go_idle(r);
    endcase
    return r;
  endfunction

  // Leave the current phase once it has been held long enough
  function automatic step_t advance(step_t s, logic sdi);
    step_t r;
    r = s;
    unique case (s.st.phase)
      PH_PRE_CS:    r = enter_ph(r, PH_PRE_CLK, sdi);
      PH_PRE_CLK:   r = enter_ph(r, PH_SEL, sdi);
      PH_SEL:       r = enter_ph(r, PH_DC_LOW, sdi);
      PH_DC_LOW:    r = enter_ph(r, PH_DC_DATA, sdi);
      PH_DC_DATA:   r = enter_ph(r, PH_DC_HIGH, sdi);
      PH_BIT_LOW:   r = enter_ph(r, PH_BIT_DATA, sdi);
      PH_BIT_DATA:  r = enter_ph(r, PH_BIT_HIGH, sdi);
      PH_DUMMY_LOW: r = enter_ph(r, PH_DUMMY_HIGH, sdi);
      PH_RD_LOW:    r = enter_ph(r, PH_RD_HIGH, sdi);
      PH_DC_HIGH: begin
        r.st.bit_idx = 3'd7;
        r = enter_ph(r, PH_BIT_LOW, sdi);
      end
      PH_DUMMY_HIGH: begin
        r.st.bit_idx = 3'd7;
        r = enter_ph(r, PH_RD_LOW, sdi);
      end
      PH_BIT_HIGH: begin
        if (s.st.bit_idx != 3'd0) begin
          r.st.bit_idx = s.st.bit_idx - 3'd1;
          r = enter_ph(r, PH_BIT_LOW, sdi);
        end else if (s.st.job != JOB_READ) begin
          r = enter_ph(r, PH_DESEL, sdi);
        end else begin
          // address sent: release the line
          r.st.pins.drv = 1'b0;
          r.st.pins.sdo = 1'b0;
          if (s.st.bytes_left > BYTES_W'(1)) begin
            r = enter_ph(r, PH_DUMMY_LOW, sdi);
          end else if (s.st.bytes_left != '0) begin
            r.st.bit_idx = 3'd7;
            r = enter_ph(r, PH_RD_LOW, sdi);
          end else begin
            r = enter_ph(r, PH_DESEL, sdi);
          end
        end
      end
      PH_RD_HIGH: begin
        if (s.st.bit_idx != 3'd0) begin
          r.st.bit_idx = s.st.bit_idx - 3'd1;
          r = enter_ph(r, PH_RD_LOW, sdi);
        end else if (s.st.bytes_left != '0) begin
          r.st.bit_idx = 3'd7;
          r = enter_ph(r, PH_RD_LOW, sdi);
        end else begin
          r = enter_ph(r, PH_DESEL, sdi);
        end
      end
      PH_DESEL: r = go_idle(r);
      default:  r = go_idle(r);
    endcase
    return r;
  endfunction

  step_t      s;
  logic [7:0] hold_len;
  logic [7:0] ticks_inc;

  assign hold_len  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign ticks_inc = st.ticks + 8'd1;

  // Tick update: count the running phase, or take a start when idle
  always_comb begin
    s.st        = st;
    s.got_valid = 1'b0;
    s.got_last  = 1'b0;
    if (st.job != JOB_IDLE) begin
      s.st.ticks = ticks_inc;
      if (ticks_inc >= hold_len) s = advance(s, sdi_in);
    end else if (op_t'(op) != OP_TICK) begin
      s.st.job     = job_t'(op);
      s.st.shift   = byte_value;
      s.st.bit_idx = 3'd7;
      if (op_t'(op) == OP_READ) begin
        s.st.bytes_left = (32'(read_count) > MAX_READ_BYTES) ? BYTES_W'(MAX_READ_BYTES)
                                                               : BYTES_W'(read_count);
      end else begin
        s.st.bytes_left = '0;
      end
      s = enter_ph(s, (op_t'(op) == OP_PARAM) ? PH_SEL : PH_PRE_CS, sdi_in);
    end
  end

  // Pin result of this tick
  always_comb begin
    st_next        = s.st;
    res.cs_level   = s.st.pins.cs;
    res.sclk_level = s.st.pins.clk;
    res.sdo_level  = s.st.pins.drv & s.st.pins.sdo;
    res.sdo_drive  = s.st.pins.drv;
    res.read_byte  = s.got_valid ? s.st.shift : 8'd0;
    res.read_valid = s.got_valid;
    res.read_last  = s.got_valid & s.got_last;
    res.busy_res   = (s.st.job != JOB_IDLE);
  end

endmodule

// ===== sv/spi_9bit_panel_master.sv =====
// Top level of the three-wire 9-bit serial panel master.
// Each input beat is one time tick of the pin sequencer and yields exactly
// one output beat with the pin levels after that tick, plus any byte that
// completed on it. A beat can be taken on every clock cycle: the tick update
// is a single pass of logic from the sequencer state and the input beat into
// the state and the output register, and the input stays ready whenever the
// output register is empty or being drained. phase_ticks (0 acts as 1) sets
// how many ticks each pin phase is held; write it only while no job is
// running. Starts arriving while busy_res is set are ignored.
`include "spi_9bit_panel_master_assert.svh"

module spi_9bit_panel_master (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data,
  spm_in_if.sink    in_ch,
  spm_out_if.source out_ch
);
  import spm_pkg::*;

  logic       [7:0] phase_ticks;
  state_t           st;
  state_t           st_next;
  result_t          res;
  result_t          res_next;
  logic             out_valid;
  logic             accept;

  // Phase length register
  always_ff @(posedge clk) begin
    if (rst) phase_ticks <= 8'd1;
    else if (cfg_write) phase_ticks <= cfg_data;
  end

  spm_step u_step (
    .st          (st),
    .op          (in_ch.op),
    .byte_value  (in_ch.byte_value),
    .read_count  (in_ch.read_count),
    .sdi_in      (in_ch.sdi_in),
    .phase_ticks (phase_ticks),
    .st_next     (st_next),
    .res         (res_next)
  );

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else if (accept) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.cs_level   = res.cs_level;
  assign out_ch.sclk_level = res.sclk_level;
  assign out_ch.sdo_level  = res.sdo_level;
  assign out_ch.sdo_drive  = res.sdo_drive;
  assign out_ch.read_byte  = res.read_byte;
  assign out_ch.read_valid = res.read_valid;
  assign out_ch.read_last  = res.read_last;
  assign out_ch.busy_res   = res.busy_res;

  // Checks
  `SPM_ASSERT_IMPL(a_last_needs_valid, clk, rst, out_valid && res.read_last, res.read_valid)
  `SPM_ASSERT_IMPL(a_released_reads_low, clk, rst, out_valid && !res.sdo_drive, !res.sdo_level)
  `SPM_ASSERT_IMPL(a_idle_pins, clk, rst, st.job == JOB_IDLE, st.pins.cs && st.pins.clk && st.pins.drv)
  `SPM_ASSERT_NEXT(a_start_taken, clk, rst, accept && st.job == JOB_IDLE && in_ch.op != OP_TICK, st.job != JOB_IDLE)

endmodule

// ===== sim/spi_9bit_panel_master_tb.sv =====
// Self-checking testbench for the three-wire 9-bit serial panel master.
`timescale 1ns / 100ps

module spi_9bit_panel_master_tb;
  import spm_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 40;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 10;

  // Level seen on the shared data line during a job
  typedef enum logic [1:0] {
    LINE_LOW    = 2'd0,
    LINE_HIGH   = 2'd1,
    LINE_RANDOM = 2'd2
  } line_mode_t;

  typedef enum logic {
    SINK_FREE    = 1'b0,
    SINK_PATTERN = 1'b1
  } sink_mode_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;

  spm_in_if  in_ch ();
  spm_out_if out_ch ();

  spi_9bit_panel_master uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Sequencer mirror: phase length, job, phase, counters, pins
  logic [7:0] hold_ticks;
  job_t       sq_job;
  phase_t     sq_phase;
  logic [2:0] sq_bit;
  logic [2:0] sq_left;
  logic [7:0] sq_shift;
  logic [7:0] sq_ticks;
  logic       pin_cs;
  logic       pin_clk;
  logic       pin_sdo;
  logic       pin_drv;
  logic       rx_done;
  logic       rx_last;
  logic [7:0] rx_byte;

  result_t    pin_expect_q[$];

  int         err_cnt = 0;
  int         beat_cnt = 0;
  int         cyc_cnt = 0;
  int         burst_left = 0;
  bit         src_gaps = 1'b1;
  sink_mode_t snk_mode = SINK_PATTERN;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  logic [15:0] stall_pat = 16'hEFB7;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pin action taken on entry to a phase
  function automatic void enter_phase(phase_t ph, logic sdi);
    sq_phase = ph;
    sq_ticks = 8'd0;
    case (ph)
      PH_PRE_CS, PH_DESEL: pin_cs = 1'b1;
      PH_SEL: pin_cs = 1'b0;
      PH_PRE_CLK, PH_DC_HIGH, PH_BIT_HIGH, PH_DUMMY_HIGH: pin_clk = 1'b1;
      PH_DC_LOW, PH_BIT_LOW: pin_clk = 1'b0;
      PH_DC_DATA: pin_sdo = (sq_job == JOB_PARAM);
      PH_BIT_DATA: pin_sdo = sq_shift[sq_bit];
      PH_DUMMY_LOW, PH_RD_LOW: begin
        pin_clk = 1'b0;
        pin_drv = 1'b0;
        pin_sdo = 1'b0;
      end
      PH_RD_HIGH: begin
        // sample on the rising clock, byte done after bit 0
        sq_shift = {sq_shift[6:0], sdi};
        if (sq_bit == 3'd0) begin
          if (sq_left != 3'd0) sq_left--;
          rx_done = 1'b1;
          rx_byte = sq_shift;
          rx_last = (sq_left == 3'd0);
        end
        pin_clk = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Move on once the current phase has been held long enough
  function automatic void advance_phase(logic sdi);
    case (sq_phase)
      PH_DC_HIGH: begin
        sq_bit = 3'd7;
        enter_phase(PH_BIT_LOW, sdi);
      end
      PH_DUMMY_HIGH: begin
        sq_bit = 3'd7;
        enter_phase(PH_RD_LOW, sdi);
      end
      PH_BIT_HIGH: begin
        if (sq_bit != 3'd0) begin
          sq_bit--;
          enter_phase(PH_BIT_LOW, sdi);
        end else if (sq_job != JOB_READ) begin
          enter_phase(PH_DESEL, sdi);
        end else begin
          // address sent: release the line
          pin_drv = 1'b0;
          pin_sdo = 1'b0;
          if (sq_left > 3'd1) begin
            enter_phase(PH_DUMMY_LOW, sdi);
          end else if (sq_left != 3'd0) begin
            sq_bit = 3'd7;
            enter_phase(PH_RD_LOW, sdi);
          end else begin
            enter_phase(PH_DESEL, sdi);
          end
        end
      end
      PH_RD_HIGH: begin
        if (sq_bit != 3'd0) begin
          sq_bit--;
          enter_phase(PH_RD_LOW, sdi);
        end else if (sq_left != 3'd0) begin
          sq_bit = 3'd7;
          enter_phase(PH_RD_LOW, sdi);
        end else begin
          enter_phase(PH_DESEL, sdi);
        end
      end
      PH_DESEL: begin
        if (sq_job == JOB_READ) begin
          pin_drv = 1'b1;
          pin_sdo = 1'b0;
        end
        sq_job   = JOB_IDLE;
        sq_phase = PH_PRE_CS;
        sq_ticks = 8'd0;
        sq_bit   = 3'd7;
      end
      PH_PRE_CS:    enter_phase(PH_PRE_CLK, sdi);
      PH_PRE_CLK:   enter_phase(PH_SEL, sdi);
      PH_SEL:       enter_phase(PH_DC_LOW, sdi);
      PH_DC_LOW:    enter_phase(PH_DC_DATA, sdi);
      PH_DC_DATA:   enter_phase(PH_DC_HIGH, sdi);
      PH_BIT_LOW:   enter_phase(PH_BIT_DATA, sdi);
      PH_BIT_DATA:  enter_phase(PH_BIT_HIGH, sdi);
      PH_DUMMY_LOW: enter_phase(PH_DUMMY_HIGH, sdi);
      PH_RD_LOW:    enter_phase(PH_RD_HIGH, sdi);
      default: ;
    endcase
  endfunction

  // One tick of the sequencer: returns the pin levels and any received byte
  function automatic result_t panel_tick(op_t op, logic [7:0] val, logic [2:0] cnt,
                                         logic sdi);
    result_t    r;
    logic [7:0] span;
    span    = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
    rx_done = 1'b0;
    rx_last = 1'b0;
    rx_byte = 8'd0;
    if (sq_job != JOB_IDLE) begin
      sq_ticks++;
      if (sq_ticks >= span) advance_phase(sdi);
    end else if (op != OP_TICK) begin
      sq_job   = job_t'(op);
      sq_shift = val;
      sq_bit   = 3'd7;
      if (op == OP_READ)
        sq_left = (cnt > MAX_READ_BYTES) ? 3'(MAX_READ_BYTES) : cnt;
      else
        sq_left = 3'd0;
      enter_phase((op == OP_PARAM) ? PH_SEL : PH_PRE_CS, sdi);
    end
    r.cs_level   = pin_cs;
    r.sclk_level = pin_clk;
    r.sdo_level  = pin_drv & pin_sdo;
    r.sdo_drive  = pin_drv;
    r.read_byte  = rx_done ? rx_byte : 8'd0;
    r.read_valid = rx_done;
    r.read_last  = rx_done & rx_last;
    r.busy_res   = (sq_job != JOB_IDLE);
    return r;
  endfunction

  function automatic logic sdi_for(line_mode_t mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < 50) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d: %s is %0h, expected %0h", beat_cnt, name, got,
                                want));
  endtask

  // Send one tick beat; bursts with random gaps when enabled
  task automatic send_beat(op_t op, logic [7:0] val, logic [2:0] cnt, logic sdi);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.byte_value <= val;
    in_ch.read_count <= cnt;
    in_ch.sdi_in     <= sdi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pin_expect_q.push_back(panel_tick(op, val, cnt, sdi));
    if (src_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // Tick until the running job is over; noise adds starts that must be ignored
  task automatic finish_job(line_mode_t mode, bit noise);
    op_t op;
    while (sq_job != JOB_IDLE) begin
      op = (noise && $urandom_range(0, 7) == 0) ? op_t'($urandom_range(1, 3)) : OP_TICK;
      send_beat(op, 8'($urandom), 3'($urandom), sdi_for(mode));
    end
  endtask

  task automatic run_job(op_t op, logic [7:0] val, logic [2:0] cnt, line_mode_t mode,
                         bit noise);
    send_beat(op, val, cnt, sdi_for(mode));
    finish_job(mode, noise);
  endtask

  task automatic drain_results;
    in_ch.valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
  endtask

  // Phase length is only changed with no job running and nothing in flight
  task automatic set_phase(logic [7:0] v);
    finish_job(LINE_RANDOM, 1'b0);
    drain_results;
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    hold_ticks = v;
  endtask

  // Command and parameter frames at the reset phase length
  task automatic test_frame_writes;
    run_job(OP_CMD, 8'h00, 3'd0, LINE_LOW, 1'b0);
    run_job(OP_CMD, 8'hFF, 3'd7, LINE_HIGH, 1'b0);
    run_job(OP_PARAM, 8'hA5, 3'd0, LINE_RANDOM, 1'b0);
    run_job(OP_PARAM, 8'h5A, 3'd2, LINE_RANDOM, 1'b0);
    // plain ticks while idle keep the pins parked
    repeat (3) send_beat(OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom));
    run_job(OP_CMD, 8'h3C, 3'd4, LINE_RANDOM, 1'b0);
  endtask

  // Reads: single byte, dummy clock, full count, zero and saturated counts
  task automatic test_register_reads;
    run_job(OP_READ, 8'hDA, 3'd1, LINE_HIGH, 1'b0);
    run_job(OP_READ, 8'hDB, 3'd2, LINE_RANDOM, 1'b0);
    run_job(OP_READ, 8'h04, 3'd4, LINE_RANDOM, 1'b0);
    run_job(OP_READ, 8'h0A, 3'd0, LINE_RANDOM, 1'b0);
    run_job(OP_READ, 8'h0B, 3'd5, LINE_LOW, 1'b0);
    run_job(OP_READ, 8'hFE, 3'd7, LINE_RANDOM, 1'b0);
  endtask

  task automatic test_ignored_starts;
    run_job(OP_CMD, 8'h11, 3'd1, LINE_RANDOM, 1'b1);
    run_job(OP_READ, 8'h45, 3'd3, LINE_RANDOM, 1'b1);
  endtask

  // Zero acts as one; a longer phase on a single short frame; then a read at phase length 2 with stray starts
  task automatic test_phase_lengths;
    set_phase(8'd0);
    run_job(OP_READ, 8'h52, 3'd2, LINE_RANDOM, 1'b0);
    run_job(OP_PARAM, 8'h29, 3'd0, LINE_RANDOM, 1'b0);
    set_phase(8'd6);
    src_gaps = 1'b0;
    run_job(OP_CMD, 8'h81, 3'd0, LINE_RANDOM, 1'b0);
    src_gaps = 1'b1;
    set_phase(8'd2);
    run_job(OP_READ, 8'hC3, 3'd4, LINE_RANDOM, 1'b1);
  endtask

  // Output held off during a read job, then a command start followed by plain ticks
  task automatic test_backpressure;
    set_phase(8'd1);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    run_job(OP_READ, 8'h0C, 3'd4, LINE_RANDOM, 1'b0);
    send_beat(OP_CMD, 8'h99, 3'd0, 1'b0);
    repeat (10) send_beat(OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom));
    drain_results;
    finish_job(LINE_RANDOM, 1'b0);
    src_gaps = 1'b1;
  endtask

  // Mostly well-formed jobs back to back, with stray starts while busy
  task automatic test_random_traffic;
    op_t        op;
    logic [2:0] cnt;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          set_phase(8'd1);
          src_gaps = 1'b1;
          snk_mode = SINK_PATTERN;
        end
        1: begin
          set_phase(8'd2);
          src_gaps = 1'b0;
          snk_mode = SINK_FREE;
        end
        2: begin
          set_phase(8'($urandom_range(3, 6)));
          src_gaps = 1'b1;
          snk_mode = SINK_FREE;
        end
        default: begin
          set_phase(8'd1);
          src_gaps = 1'b1;
          snk_mode = SINK_PATTERN;
        end
      endcase
      for (int i = 0; i < 72; i++) begin
        if (sq_job == JOB_IDLE && $urandom_range(0, 9) != 0)
          op = op_t'($urandom_range(1, 3));
        else if (sq_job != JOB_IDLE && $urandom_range(0, 11) == 0)
          op = op_t'($urandom_range(0, 3));
        else
          op = OP_TICK;
        cnt = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        send_beat(op, 8'($urandom), cnt, 1'($urandom));
      end
    end
  endtask

  // Output ready: a long hold on request, else free or a rotating stall pattern
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (snk_mode == SINK_FREE) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        if ($urandom_range(0, 63) == 0) stall_pat = 16'($urandom | $urandom);
      end
    end
  end

  // Compare every output beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pin_expect_q.size() == 0) begin
        report_mismatch($sformatf("beat %0d: output beat with nothing expected", beat_cnt));
      end else begin
        want = pin_expect_q.pop_front();
        check_field("cs_level", 8'(out_ch.cs_level), 8'(want.cs_level));
        check_field("sclk_level", 8'(out_ch.sclk_level), 8'(want.sclk_level));
        check_field("sdo_level", 8'(out_ch.sdo_level), 8'(want.sdo_level));
        check_field("sdo_drive", 8'(out_ch.sdo_drive), 8'(want.sdo_drive));
        check_field("read_byte", out_ch.read_byte, want.read_byte);
        check_field("read_valid", 8'(out_ch.read_valid), 8'(want.read_valid));
        check_field("read_last", 8'(out_ch.read_last), 8'(want.read_last));
        check_field("busy_res", 8'(out_ch.busy_res), 8'(want.busy_res));
      end
      beat_cnt++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("FAIL spi_9bit_panel_master");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_data         = 8'd0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_TICK;
    in_ch.byte_value = 8'd0;
    in_ch.read_count = 3'd0;
    in_ch.sdi_in     = 1'b0;
    // mirror starts from the reset state
    hold_ticks = 8'd1;
    sq_job     = JOB_IDLE;
    sq_phase   = PH_PRE_CS;
    sq_bit     = 3'd7;
    sq_left    = 3'd0;
    sq_shift   = 8'd0;
    sq_ticks   = 8'd0;
    pin_cs     = 1'b1;
    pin_clk    = 1'b1;
    pin_sdo    = 1'b0;
    pin_drv    = 1'b1;
    rx_done    = 1'b0;
    rx_last    = 1'b0;
    rx_byte    = 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_frame_writes;
    test_register_reads;
    test_ignored_starts;
    test_phase_lengths;
    test_backpressure;
    test_random_traffic;
    finish_job(LINE_RANDOM, 1'b0);
    drain_results;
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("PASS spi_9bit_panel_master");
    else
      $display("FAIL spi_9bit_panel_master");
    $finish;
  end

endmodule
